// ----- rtl/string_hash_table_engine_defines.svh -----
// Assertion macros shared by the string hash table engine modules.
// Each macro expects signals named clk and rst in the scope that uses it.
`ifndef STRING_HASH_TABLE_ENGINE_DEFINES_SVH
`define STRING_HASH_TABLE_ENGINE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHTE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SHTE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/shte_pkg.sv -----
// Shared types, constants and the hash table constant builder.
// Used by shte_ctrl, shte_datapath and string_hash_table_engine.
`default_nettype none

package shte_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int LG_W        = 4;
  localparam int ROM_WORDS   = 1280;
  localparam int ROM_AW      = $clog2(ROM_WORDS);
  localparam logic [31:0] SEED_A = 32'h7FED7FED;
  localparam logic [31:0] SEED_B = 32'hEEEEEEEE;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_PRESENT   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] char_code;
    logic       has_char;
    logic       last;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [11:0] position;
  } result_t;

  typedef struct packed {
    logic       capture;
    logic       rom_rd;
    logic       fold;
    logic [1:0] ht;
    logic       probe_start;
    logic       mem_rd;
    logic       probe_step;
    logic       insert;
    logic       emit;
    status_t    emit_status;
    logic       clr_step;
  } cmd_t;

  typedef struct packed {
    logic has_char;
    logic last;
    logic is_add;
    logic ent_valid;
    logic ent_match;
    logic probe_last;
    logic clr_done;
  } sts_t;

  typedef logic [31:0] rom_t [ROM_WORDS];

  // Builds the constant table with the fixed LCG; evaluated at elaboration.
  function automatic rom_t build_rom();
    rom_t        r;
    logic [31:0] x;
    logic [31:0] hi;
    logic [31:0] lo;
    x = 32'h00100001;
    for (int col = 0; col < 256; col++) begin
      for (int k = 0; k < 5; k++) begin
        x  = (x * 32'd125 + 32'd3) % 32'h2AAAAB;
        hi = {x[15:0], 16'h0000};
        x  = (x * 32'd125 + 32'd3) % 32'h2AAAAB;
        lo = {16'h0000, x[15:0]};
        r[col + k * 256] = hi | lo;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/shte_ctrl.sv -----
// Controller state machine: sequences character folding, table probing and clearing.
// Depends on shte_pkg and string_hash_table_engine_defines.svh.
`default_nettype none
`include "string_hash_table_engine_defines.svh"

module shte_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic          cfg_we,
  input  wire shte_pkg::sts_t sts,
  output shte_pkg::cmd_t     cmd,
  output logic               busy
);
  import shte_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ROM_RD,
    S_FOLD,
    S_PROBE_START,
    S_PROBE_RD,
    S_PROBE_CMP
  } state_t;

  state_t     state, state_next;
  logic [1:0] ht, ht_next;

  always_comb begin
    state_next = state;
    ht_next    = ht;
    cmd        = '0;
    cmd.ht     = ht;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          // Decode the word being captured straight from the status bus.
          if (sts.has_char) state_next = S_ROM_RD;
          else if (sts.last) state_next = S_PROBE_START;
        end
      end
      S_ROM_RD: begin
        cmd.rom_rd = 1'b1;
        state_next = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        if (ht == 2'd2) begin
          ht_next    = 2'd0;
          state_next = sts.last ? S_PROBE_START : S_IDLE;
        end else begin
          ht_next    = ht + 2'd1;
          state_next = S_ROM_RD;
        end
      end
      S_PROBE_START: begin
        cmd.probe_start = 1'b1;
        state_next      = S_PROBE_RD;
      end
      S_PROBE_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = S_PROBE_CMP;
      end
      S_PROBE_CMP: begin
        if (!sts.ent_valid) begin
          cmd.emit        = 1'b1;
          cmd.insert      = sts.is_add;
          cmd.emit_status = sts.is_add ? ST_OK : ST_NOT_FOUND;
          state_next      = S_IDLE;
        end else if (sts.ent_match) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = sts.is_add ? ST_PRESENT : ST_OK;
          state_next      = S_IDLE;
        end else if (sts.probe_last) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = sts.is_add ? ST_FULL : ST_NOT_FOUND;
          state_next      = S_IDLE;
        end else begin
          cmd.probe_step = 1'b1;
          state_next     = S_PROBE_RD;
        end
      end
      default: state_next = S_CLEAR;
    endcase
    // A size write restarts the clearing sweep.
    if (cfg_we) state_next = S_CLEAR;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ht    <= 2'd0;
      busy  <= 1'b1;
    end else begin
      state <= state_next;
      ht    <= ht_next;
      busy  <= (state_next != S_IDLE);
    end
  end

  `SHTE_ASSERT_NEXT(a_cfg_clears, cfg_we, state == S_CLEAR)
  `SHTE_ASSERT_NOW(a_busy_state, !busy, state == S_IDLE)
  `SHTE_ASSERT_NOW(a_ht_range, 1'b1, ht != 2'd3)

endmodule

`default_nettype wire

// ----- rtl/shte_datapath.sv -----
// Datapath: hash registers, constant table, entry memory, probe and clear counters.
// Depends on shte_pkg and string_hash_table_engine_defines.svh.
`default_nettype none
`include "string_hash_table_engine_defines.svh"

module shte_datapath (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire shte_pkg::req_t          req,
  input  wire logic                    cfg_we,
  input  wire logic [shte_pkg::LG_W-1:0] cfg_data,
  input  wire shte_pkg::cmd_t          cmd,
  output shte_pkg::sts_t               sts,
  output logic                         done,
  output shte_pkg::result_t            result
);
  import shte_pkg::*;

  localparam rom_t CRYPT_ROM = build_rom();

  logic [7:0]        ch;
  logic              is_add;
  logic              has_char;
  logic              last;
  logic [7:0]        ch_up;
  logic [31:0]       s1 [3];
  logic [31:0]       s2 [3];
  logic [31:0]       rom_q;
  logic [31:0]       s1_next;
  logic [31:0]       s2_next;
  logic [ADDR_W-1:0] mask;
  logic [ADDR_W-1:0] mask_next;
  logic [ADDR_W:0]   size_sh;
  logic [ADDR_W-1:0] pos;
  logic [ADDR_W-1:0] steps;
  logic [ADDR_W-1:0] clr_addr;
  logic [64:0]       mem [TABLE_DEPTH];
  logic [64:0]       mem_q;
  logic              zero_pos;

  assign ch_up = (ch >= 8'h61 && ch <= 8'h7A) ? ch - 8'h20 : ch;

  // One hash type per fold: the type picks the table bank and the hash pair.
  assign s1_next = rom_q ^ (s1[cmd.ht] + s2[cmd.ht]);
  assign s2_next = {24'h0, ch_up} + s1_next + s2[cmd.ht] + {s2[cmd.ht][26:0], 5'b0} + 32'd3;

  // Sizes past the memory depth saturate to the full table.
  assign size_sh   = (ADDR_W + 1)'(1) << cfg_data;
  assign mask_next = (cfg_data > LG_W'(ADDR_W)) ? '1 : ADDR_W'(size_sh - 1'b1);

  always_comb begin
    sts            = '0;
    sts.has_char   = cmd.capture ? req.has_char : has_char;
    sts.last       = cmd.capture ? req.last : last;
    sts.is_add     = is_add;
    sts.ent_valid  = mem_q[64];
    sts.ent_match  = (mem_q[63:32] == s1[1]) && (mem_q[31:0] == s1[2]);
    sts.probe_last = (steps == mask);
    sts.clr_done   = (clr_addr == '1);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ch       <= req.char_code;
      is_add   <= req.req_type;
      has_char <= req.has_char;
      last     <= req.last;
    end
    if (cmd.rom_rd) rom_q <= CRYPT_ROM[{1'b0, cmd.ht, ch_up}];
    if (cmd.probe_start) begin
      pos   <= s1[0][ADDR_W-1:0] & mask;
      steps <= '0;
    end else if (cmd.probe_step) begin
      pos   <= (pos + 1'b1) & mask;
      steps <= steps + 1'b1;
    end
    if (cmd.clr_step) mem[clr_addr] <= '0;
    else if (cmd.insert) mem[pos] <= {1'b1, s1[1], s1[2]};
    if (cmd.mem_rd) mem_q <= mem[pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < 3; t++) begin
        s1[t] <= SEED_A;
        s2[t] <= SEED_B;
      end
      mask     <= '1;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (cmd.emit) begin
        for (int t = 0; t < 3; t++) begin
          s1[t] <= SEED_A;
          s2[t] <= SEED_B;
        end
      end else if (cmd.fold) begin
        s1[cmd.ht] <= s1_next;
        s2[cmd.ht] <= s2_next;
      end
      if (cfg_we) begin
        mask     <= mask_next;
        clr_addr <= '0;
      end else if (cmd.clr_step) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.status   <= cmd.emit_status;
      result.position <= (cmd.emit_status == ST_OK || cmd.emit_status == ST_PRESENT)
                         ? 12'(pos) : 12'd0;
    end
  end

  assign zero_pos = (result.status == ST_NOT_FOUND) || (result.status == ST_FULL);

  `SHTE_ASSERT_NEXT(a_one_strobe, done, !done)
  `SHTE_ASSERT_NOW(a_zero_pos, done && zero_pos, result.position == 12'd0)
  `SHTE_ASSERT_NOW(a_no_clash, cmd.insert, !cmd.clr_step)

endmodule

`default_nettype wire

// ----- rtl/string_hash_table_engine.sv -----
// Top level of the string hash table engine: controller plus datapath.
// Depends on shte_pkg, shte_ctrl and shte_datapath.
//
//   port group          dir  timing
//   start/busy, req     in   word taken when start is high and busy is low
//   done, result        out  word shown for one cycle, marked by done
//   cfg_we, cfg_data    in   size register written when cfg_we is high
//
// A word with a character goes through capture, then a table read and a
// fold for each of the three hashes, through the single constant table port.
// A last word adds a probe start, then an entry memory read and a compare
// for each probed entry, up to the table size; the result appears in the
// cycle after the final compare. After reset and after every size write, all
// 4096 entries are swept clear, with busy high. Results cannot stall.
`default_nettype none

module string_hash_table_engine (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire shte_pkg::req_t            req,
  input  wire logic                      cfg_we,
  input  wire logic [shte_pkg::LG_W-1:0] cfg_data,
  output logic                           done,
  output shte_pkg::result_t              result
);
  import shte_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic ctrl_busy;

  shte_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cfg_we (cfg_we),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (ctrl_busy)
  );

  shte_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .done     (done),
    .result   (result)
  );

  assign busy = ctrl_busy;

endmodule

`default_nettype wire

// ----- verif/string_hash_table_engine_test.sv -----
// Self-checking testbench for the string hash table engine: keys are sent a
// character per word and every probe result is checked against a scoreboard.
// Depends on shte_pkg and the string_hash_table_engine RTL.
`default_nettype none

module string_hash_table_engine_test;
  timeunit 1ns;
  timeprecision 1ps;
  import shte_pkg::*;

  localparam int CYCLE_LIMIT = 20000000;

  class hash_table_scoreboard;
    logic [31:0] crypt_words [1280];
    logic [31:0] seeds [6];
    bit          in_use [4096];
    logic [31:0] word_a [4096];
    logic [31:0] word_b [4096];
    logic [11:0] mask;
    result_t     pending [$];
    int          fails;

    function new();
      logic [31:0] x;
      logic [31:0] hi;
      x = 32'h00100001;
      for (int c = 0; c < 256; c++) begin
        for (int k = 0; k < 5; k++) begin
          x  = (x * 32'd125 + 32'd3) % 32'h2AAAAB;
          hi = x & 32'hFFFF;
          x  = (x * 32'd125 + 32'd3) % 32'h2AAAAB;
          crypt_words[c + k * 256] = (hi << 16) | (x & 32'hFFFF);
        end
      end
      fails = 0;
      reseed();
      resize(4'd12);
    endfunction

    function void reseed();
      for (int t = 0; t < 3; t++) begin
        seeds[2 * t]     = SEED_A;
        seeds[2 * t + 1] = SEED_B;
      end
    endfunction

    // Oversized tables saturate to the full entry memory; any write clears it.
    function void resize(logic [3:0] lg);
      int n;
      n = (lg > 12) ? 12 : lg;
      mask = 12'((1 << n) - 1);
      for (int i = 0; i < 4096; i++) in_use[i] = 0;
    endfunction

    function void note_word(req_t r);
      logic [31:0] ch;
      logic [31:0] s1;
      logic [31:0] s2;
      logic [11:0] pos;
      result_t     res;
      bit          settled;
      if (r.has_char) begin
        ch = {24'd0, r.char_code};
        if (ch >= 32'h61 && ch <= 32'h7A) ch = ch - 32'h20;
        for (int t = 0; t < 3; t++) begin
          s1 = seeds[2 * t];
          s2 = seeds[2 * t + 1];
          s1 = crypt_words[t * 256 + ch] ^ (s1 + s2);
          s2 = ch + s1 + s2 + (s2 << 5) + 32'd3;
          seeds[2 * t]     = s1;
          seeds[2 * t + 1] = s2;
        end
      end
      if (!r.last) return;
      pos = seeds[0][11:0] & mask;
      res.status   = ST_NOT_FOUND;
      res.position = '0;
      settled      = 0;
      for (int s = 0; s <= int'(mask) && !settled; s++) begin
        if (!in_use[pos]) begin
          if (r.req_type) begin
            in_use[pos] = 1;
            word_a[pos] = seeds[2];
            word_b[pos] = seeds[4];
            res.status   = ST_OK;
            res.position = pos;
          end
          settled = 1;
        end else if (word_a[pos] == seeds[2] && word_b[pos] == seeds[4]) begin
          res.status   = r.req_type ? ST_PRESENT : ST_OK;
          res.position = pos;
          settled = 1;
        end else begin
          pos = (pos + 12'd1) & mask;
        end
      end
      if (!settled) res.status = r.req_type ? ST_FULL : ST_NOT_FOUND;
      reseed();
      pending.push_back(res);
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result status %0d position %0d", got.status, got.position);
        fails++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $error("status expected %0d actual %0d", want.status, got.status);
        fails++;
      end
      if (got.position !== want.position) begin
        $error("position expected %0d actual %0d", want.position, got.position);
        fails++;
      end
    endfunction
  endclass

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  req_t     req;
  logic     cfg_we;
  logic [LG_W-1:0] cfg_data;
  logic     done;
  result_t  result;

  hash_table_scoreboard sb;
  int          cycles = 0;
  bit          allow_idle;
  logic [7:0]  key_chars [32][6];
  int          key_len [32];

  string_hash_table_engine uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .done(done), .result(result)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("string_hash_table_engine verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_word(result);
  end

  // Called at a rising edge; returns after the word is taken and any idle gap.
  task automatic send_word(logic add, logic [7:0] ch, logic has, logic fin);
    req_t r;
    r.req_type  = add;
    r.char_code = ch;
    r.has_char  = has;
    r.last      = fin;
    start <= 1'b1;
    req   <= r;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    sb.note_word(r);
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    // A character word may still be folding after the last result.
    repeat (12) @(posedge clk);
  endtask

  task automatic write_size(logic [3:0] lg);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= lg;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.resize(lg);
    repeat (3) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_char();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 8'h61 + 8'($urandom_range(0, 25));
    if (sel < 8) return 8'h41 + 8'($urandom_range(0, 25));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic new_key(int k);
    key_len[k] = $urandom_range(0, 5);
    for (int i = 0; i < 6; i++) key_chars[k][i] = pick_char();
  endtask

  // Sends one key with filler words that carry no character.
  task automatic send_key(int k, logic add);
    bit trailer;
    bit fin;
    trailer = (key_len[k] == 0) || ($urandom_range(0, 3) == 0);
    for (int i = 0; i < key_len[k]; i++) begin
      if ($urandom_range(0, 7) == 0)
        send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, 1'b0);
      fin = !trailer && i == key_len[k] - 1;
      send_word(fin ? add : 1'($urandom_range(0, 1)), key_chars[k][i], 1'b1, fin);
    end
    if (trailer) send_word(add, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic random_phase(int keys, int pool);
    int k;
    for (int n = 0; n < keys; n++) begin
      k = $urandom_range(0, pool - 1);
      if ($urandom_range(0, 4) == 0) new_key(k);
      if ($urandom_range(0, 19) == 0) begin
        // Broken sequence: a word without last, then a normal key.
        send_word(1'($urandom_range(0, 1)), pick_char(), 1'b1, 1'b0);
      end
      send_key(k, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    logic [3:0] sizes [9];
    sizes = '{4'd0, 4'd1, 4'd2, 4'd15, 4'd3, 4'd13, 4'd2, 4'd5, 4'd12};
    sb = new();
    allow_idle = 0;
    rst      = 1'b1;
    start    = 1'b0;
    req      = '0;
    cfg_we   = 1'b0;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty key, zero byte, top byte, case folding, key with gap.
    send_word(1'b1, 8'h00, 1'b0, 1'b1);
    send_word(1'b1, 8'hFF, 1'b0, 1'b1);
    send_word(1'b0, 8'h00, 1'b0, 1'b1);
    send_word(1'b0, 8'h00, 1'b1, 1'b1);
    send_word(1'b1, 8'h00, 1'b1, 1'b1);
    send_word(1'b0, 8'h00, 1'b1, 1'b1);
    send_word(1'b1, 8'hFF, 1'b1, 1'b1);
    send_word(1'b0, 8'h61, 1'b1, 1'b0);
    send_word(1'b1, 8'h7A, 1'b1, 1'b1);
    send_word(1'b1, 8'h41, 1'b1, 1'b0);
    send_word(1'b0, 8'h33, 1'b0, 1'b0);
    send_word(1'b0, 8'h5A, 1'b1, 1'b1);
    send_word(1'b0, 8'h60, 1'b1, 1'b1);
    send_word(1'b0, 8'h7B, 1'b1, 1'b1);
    write_size(4'd0);
    send_word(1'b1, 8'h42, 1'b1, 1'b1);
    send_word(1'b1, 8'h43, 1'b1, 1'b1);
    send_word(1'b0, 8'h43, 1'b1, 1'b1);
    send_word(1'b1, 8'h42, 1'b1, 1'b1);
    // A size write between character words keeps the partial key.
    send_word(1'b0, 8'h44, 1'b1, 1'b0);
    write_size(4'd1);
    send_word(1'b1, 8'h45, 1'b1, 1'b1);

    for (int k = 0; k < 32; k++) new_key(k);
    allow_idle = 1;
    foreach (sizes[p]) begin
      write_size(sizes[p]);
      random_phase(7, (sizes[p] < 4) ? 8 : 32);
      if (p == 4) drain();
      random_phase(7, (sizes[p] < 4) ? 8 : 32);
    end
    allow_idle = 0;
    random_phase(20, 32);

    drain();
    repeat (20) @(posedge clk);
    if (sb.fails == 0) begin
      $display("string_hash_table_engine verification clean");
    end else begin
      $display("string_hash_table_engine verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
